[rtl/bmhq_pkg.sv]
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types, sizes and codes of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 16;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 2'd0,
    CMD_POP       = 2'd1,
    CMD_REMOVE_AT = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RM,
    S_UP,
    S_DN,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } ram_req_t;

  // Heap positions are 1-based; the store is 0-based.
  function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W:0] pos);
    logic [CNT_W:0] tmp;
    tmp = pos - {{CNT_W{1'b0}}, 1'b1};
    return tmp[ADDR_W-1:0];
  endfunction

endpackage

[rtl/bmhq_if.sv]
// ----------------------------------------------------------------------------
// bmhq_if
// Valid/ready channel interfaces for commands in and results out.
// ----------------------------------------------------------------------------
interface bmhq_in_if import bmhq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [KEY_W-1:0]  new_key;
  logic [TAG_W-1:0]  new_tag;
  logic [CNT_W-1:0]  position;

  modport source(output valid, command, new_key, new_tag, position, input ready);
  modport sink(input valid, command, new_key, new_tag, position, output ready);
endinterface

interface bmhq_out_if import bmhq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  removed_key;
  logic [TAG_W-1:0]  removed_tag;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  count;

  modport source(output valid, removed_key, removed_tag, status, count, input ready);
  modport sink(input valid, removed_key, removed_tag, status, count, output ready);
endinterface

[rtl/bmhq_ram.sv]
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

[rtl/bmhq_ctrl.sv]
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Command sequencer: reads, compares and writes back heap entries level by
// level, and holds the result register.
// ----------------------------------------------------------------------------
module bmhq_ctrl import bmhq_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  bmhq_in_if.sink       in_ch,
  bmhq_out_if.source    out_ch,
  output ram_req_t      ram_req,
  input  entry_t        rd_a,
  input  entry_t        rd_b
);

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  entry_t             new_r, new_nxt;
  logic [CNT_W-1:0]   pos_in_r, pos_in_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   p_r, p_nxt;
  entry_t             e_r, e_nxt;
  logic               rgt_r, rgt_nxt;
  logic [KEY_W-1:0]   res_key_r, res_key_nxt;
  logic [TAG_W-1:0]   res_tag_r, res_tag_nxt;
  stat_t              res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [TAG_W-1:0]   out_tag_r, out_tag_nxt;
  stat_t              out_st_r, out_st_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    new_r     <= new_nxt;
    pos_in_r  <= pos_in_nxt;
    p_r       <= p_nxt;
    e_r       <= e_nxt;
    rgt_r     <= rgt_nxt;
    res_key_r <= res_key_nxt;
    res_tag_r <= res_tag_nxt;
    res_st_r  <= res_st_nxt;
    out_key_r <= out_key_nxt;
    out_tag_r <= out_tag_nxt;
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.removed_key = out_key_r;
  assign out_ch.removed_tag = out_tag_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.count       = out_cnt_r;

  always_comb begin
    logic             do_up;
    logic             do_dn;
    logic [CNT_W-1:0] up_p;
    logic [CNT_W-1:0] dn_p;
    logic [CNT_W-1:0] dn_cnt;
    logic [CNT_W-1:0] at;
    logic [CNT_W:0]   two_p;
    logic [CNT_W-1:0] par;
    logic [CNT_W-1:0] c;
    entry_t           child;

    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    new_nxt       = new_r;
    pos_in_nxt    = pos_in_r;
    cnt_nxt       = cnt_r;
    p_nxt         = p_r;
    e_nxt         = e_r;
    rgt_nxt       = rgt_r;
    res_key_nxt   = res_key_r;
    res_tag_nxt   = res_tag_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_tag_nxt   = out_tag_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    ram_req       = '0;
    do_up         = 1'b0;
    do_dn         = 1'b0;
    up_p          = p_r;
    dn_p          = p_r;
    dn_cnt        = cnt_r;
    at            = '0;
    two_p         = {p_r, 1'b0};
    par           = p_r >> 1;
    c             = two_p[CNT_W-1:0];
    child         = rd_a;

    // drain the result register
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt    = cmd_t'(in_ch.command);
          new_nxt    = {in_ch.new_key, in_ch.new_tag};
          pos_in_nxt = in_ch.position;
          state_nxt  = S_START;
        end
      end

      S_START: begin
        res_key_nxt = '0;
        res_tag_nxt = '0;
        res_st_nxt  = STAT_OK;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              res_st_nxt = STAT_FULL;
              state_nxt  = S_DONE;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
              e_nxt   = new_r;
              p_nxt   = cnt_r + 1'b1;
              up_p    = cnt_r + 1'b1;
              do_up   = 1'b1;
            end
          end
          CMD_POP, CMD_REMOVE_AT: begin
            at = (cmd_r == CMD_POP) ? CNT_W'(1) : pos_in_r;
            if (cnt_r == '0 || at == '0 || at > cnt_r) begin
              res_st_nxt = STAT_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              // fetch the removed entry and the last entry together
              p_nxt             = at;
              ram_req.rd_addr_a = addr_of({1'b0, at});
              ram_req.rd_addr_b = addr_of({1'b0, cnt_r});
              state_nxt         = S_RM;
            end
          end
          default: begin
            res_st_nxt = STAT_EMPTY;
            state_nxt  = S_DONE;
          end
        endcase
      end

      S_RM: begin
        res_key_nxt = rd_a.key;
        res_tag_nxt = rd_a.tag;
        cnt_nxt     = cnt_r - 1'b1;
        if (p_r == cnt_r) begin
          // the last entry itself was removed
          state_nxt = S_DONE;
        end else begin
          e_nxt = rd_b;
          if ($signed(rd_b.key) >= $signed(rd_a.key)) begin
            do_up = 1'b1;
          end else begin
            dn_cnt = cnt_r - 1'b1;
            do_dn  = 1'b1;
          end
        end
      end

      S_UP: begin
        if ($signed(e_r.key) > $signed(rd_a.key)) begin
          // move the parent down into the hole
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = addr_of({1'b0, p_r});
          ram_req.wr_data = rd_a;
          p_nxt           = par;
          up_p            = par;
          do_up           = 1'b1;
        end else begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = addr_of({1'b0, p_r});
          ram_req.wr_data = e_r;
          state_nxt       = S_DONE;
        end
      end

      S_DN: begin
        if (rgt_r && ($signed(rd_b.key) > $signed(rd_a.key))) begin
          c     = two_p[CNT_W-1:0] + 1'b1;
          child = rd_b;
        end
        if ($signed(e_r.key) < $signed(child.key)) begin
          // move the larger child up into the hole
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = addr_of({1'b0, p_r});
          ram_req.wr_data = child;
          p_nxt           = c;
          dn_p            = c;
          do_dn           = 1'b1;
        end else begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = addr_of({1'b0, p_r});
          ram_req.wr_data = e_r;
          state_nxt       = S_DONE;
        end
      end

      S_FIN: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = addr_of({1'b0, p_r});
        ram_req.wr_data = e_r;
        state_nxt       = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = res_key_r;
          out_tag_nxt   = res_tag_r;
          out_st_nxt    = res_st_r;
          out_cnt_nxt   = cnt_nxt;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // next sift-up level: stop at the root, else fetch the parent
    if (do_up) begin
      if (up_p == CNT_W'(1)) begin
        state_nxt = S_FIN;
      end else begin
        ram_req.rd_addr_a = addr_of({1'b0, up_p >> 1});
        state_nxt         = S_UP;
      end
    end

    // next sift-down level: stop at a leaf, else fetch both children
    if (do_dn) begin
      two_p = {dn_p, 1'b0};
      if (two_p > {1'b0, dn_cnt}) begin
        state_nxt = S_FIN;
      end else begin
        ram_req.rd_addr_a = addr_of(two_p);
        ram_req.rd_addr_b = two_p[ADDR_W-1:0];
        rgt_nxt           = (two_p < {1'b0, dn_cnt});
        state_nxt         = S_DN;
      end
    end
  end

endmodule

[rtl/binary_max_heap_queue.sv]
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Max-heap priority queue of signed keys with tags: insert, pop the top and
// remove at a heap position, one result transaction per command transaction.
//
// Sequence: a rejected command goes from the start state straight to the
//   done state. Insert compares one level per step and adds a final write
//   step on reaching the root; removal adds a fetch step, compares one level
//   per step and adds a final write step at the root or a leaf.
// Throughput: one command in flight; the next command is taken the cycle after
//   the result loads into the output register, which waits while an earlier
//   result is held off.
// Reset: rst_n clears the entry count and control; the heap store is not
//   cleared, only positions 1..count are ever used.
// ----------------------------------------------------------------------------
module binary_max_heap_queue import bmhq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bmhq_in_if.sink    in_ch,
  bmhq_out_if.source out_ch
);

  ram_req_t ram_req;
  entry_t   rd_a;
  entry_t   rd_b;

  // Sequencer: holds the moving entry in a register and walks the hole
  // up or down the tree, one compare per cycle against registered reads.
  bmhq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .ram_req (ram_req),
    .rd_a    (rd_a),
    .rd_b    (rd_b)
  );

  // Heap store: port b reads the last entry on removal and the right child
  // while sifting down.
  bmhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk       (clk),
    .wr_en     (ram_req.wr_en),
    .wr_addr   (ram_req.wr_addr),
    .wr_data   (ram_req.wr_data),
    .rd_addr_a (ram_req.rd_addr_a),
    .rd_data_a (rd_a),
    .rd_addr_b (ram_req.rd_addr_b),
    .rd_data_b (rd_b)
  );

endmodule

[tb/sv/tb_binary_max_heap_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_max_heap_queue
// Self-checking bench for the max-heap priority queue. A queue of planned
// commands feeds a clocked driver. A clocked monitor compares every result
// transaction, field by field, with a heap predictor that runs alongside.
// A short directed sequence hits the extremes, ties and each error but a full heap.
// Random phases then fill, churn and drain the heap, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module tb_binary_max_heap_queue;
  import bmhq_pkg::*;

  localparam int          CLK_PERIOD    = 10;
  localparam int          RESET_CYCLES  = 4;
  localparam int          RANDOM_ITEMS  = 1800;
  localparam int          MAX_IDLE      = 12;
  localparam int          HOLD_AFTER    = 400;   // results seen before the long hold-off
  localparam int          HOLD_CYCLES   = 400;
  localparam int          SETTLE_CYCLES = 30;
  localparam int          POS_MAX       = (1 << CNT_W) - 1;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;  // no meaning, answered as an error

  // One planned command transaction plus how the sender paces it.
  typedef struct {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] position;
    int unsigned      gap;
    bit               wait_drain;
  } heap_cmd_t;

  typedef struct {
    logic [KEY_W-1:0]  removed_key;
    logic [TAG_W-1:0]  removed_tag;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } heap_result_t;

  typedef struct {
    int               key;
    logic [TAG_W-1:0] tag;
  } slot_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bmhq_in_if  cmd_ch ();
  bmhq_out_if res_ch ();

  binary_max_heap_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  heap_cmd_t    pending_cmds[$];
  heap_result_t expected_results[$];
  int unsigned  total_cmds;
  int unsigned  cmds_sent;
  int unsigned  results_seen;
  int unsigned  mismatch_count;

  // --------------------------------------------------------------------------
  // Heap predictor: 1-based array, positions 1..model_count are live.
  // --------------------------------------------------------------------------
  slot_t       heap_model [1:CAPACITY];
  int unsigned model_count;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    slot_t t;
    t = heap_model[a];
    heap_model[a] = heap_model[b];
    heap_model[b] = t;
  endfunction

  // Move up while strictly greater than the parent; equal keys stay put.
  function automatic void sift_toward_root(int unsigned p);
    while (p > 1 && heap_model[p].key > heap_model[p / 2].key) begin
      swap_slots(p, p / 2);
      p = p / 2;
    end
  endfunction

  // Take the right child only when strictly greater than the left one, and
  // swap only when that child is strictly greater than the parent.
  function automatic void sift_toward_leaves(int unsigned p);
    int unsigned c;
    bit          done;
    done = 1'b0;
    while (!done && 2 * p <= model_count) begin
      c = 2 * p;
      if (c + 1 <= model_count && heap_model[c + 1].key > heap_model[c].key) c++;
      if (heap_model[p].key < heap_model[c].key) begin
        swap_slots(p, c);
        p = c;
      end else begin
        done = 1'b1;
      end
    end
  endfunction

  function automatic heap_result_t apply_heap_command(heap_cmd_t c);
    heap_result_t r;
    slot_t        gone;
    slot_t        last;
    int unsigned  at;
    r.removed_key = '0;
    r.removed_tag = '0;
    r.status      = STAT_OK;
    case (c.command)
      CMD_INSERT: begin
        if (model_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          model_count++;
          heap_model[model_count].key = c.key;
          heap_model[model_count].tag = c.tag;
          sift_toward_root(model_count);
        end
      end
      CMD_POP, CMD_REMOVE_AT: begin
        at = (c.command == CMD_POP) ? 1 : c.position;
        if (model_count == 0 || at == 0 || at > model_count) begin
          r.status = STAT_EMPTY;
        end else begin
          // Fill the hole with the last entry, then restore order either way.
          gone = heap_model[at];
          last = heap_model[model_count];
          model_count--;
          if (at <= model_count) begin
            heap_model[at] = last;
            if (last.key >= gone.key) sift_toward_root(at);
            else sift_toward_leaves(at);
          end
          r.removed_key = gone.key;
          r.removed_tag = gone.tag;
        end
      end
      default: r.status = STAT_EMPTY;
    endcase
    r.count = CNT_W'(model_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus planning. plan_count tracks the heap size the planned commands
  // will leave behind, so removals can aim at live or dead positions.
  // --------------------------------------------------------------------------
  int unsigned plan_count;

  function automatic void plan_cmd(logic [CMD_W-1:0] op, logic [KEY_W-1:0] key,
                                   logic [TAG_W-1:0] tag, logic [CNT_W-1:0] pos,
                                   bit wait_drain);
    heap_cmd_t c;
    c.command    = op;
    c.key        = key;
    c.tag        = tag;
    c.position   = pos;
    c.gap        = $urandom_range(0, MAX_IDLE);
    c.wait_drain = wait_drain;
    pending_cmds.push_back(c);
    case (op)
      CMD_INSERT:    if (plan_count < CAPACITY) plan_count++;
      CMD_POP:       if (plan_count > 0) plan_count--;
      CMD_REMOVE_AT: if (pos >= 1 && pos <= plan_count) plan_count--;
      default: ;
    endcase
  endfunction

  // One random command; tie_keys narrows keys so equal keys meet often.
  function automatic void plan_random(int unsigned insert_pct, bit tie_keys,
                                      bit wait_drain);
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] pos;
    int unsigned      pick;
    key  = tie_keys ? KEY_W'($urandom_range(0, 6) - 3) : KEY_W'($urandom);
    pick = $urandom_range(0, 19);
    if (pick == 0) key = 32'h7FFF_FFFF;
    if (pick == 1) key = 32'h8000_0000;
    pos = CNT_W'($urandom);
    if ($urandom_range(0, 99) < insert_pct) begin
      plan_cmd(CMD_INSERT, key, TAG_W'($urandom), pos, wait_drain);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        plan_cmd(CMD_POP, key, TAG_W'($urandom), pos, wait_drain);
      end else if (pick < 88) begin
        // Aim at a live entry, the last one fairly often.
        if (plan_count > 0)
          pos = ($urandom_range(0, 3) == 0) ? CNT_W'(plan_count)
                                            : CNT_W'($urandom_range(1, plan_count));
        plan_cmd(CMD_REMOVE_AT, key, TAG_W'($urandom), pos, wait_drain);
      end else if (pick < 96) begin
        pos = $urandom_range(0, 1) ? '0 : CNT_W'($urandom_range(plan_count + 1, POS_MAX));
        plan_cmd(CMD_REMOVE_AT, key, TAG_W'($urandom), pos, wait_drain);
      end else begin
        plan_cmd(CMD_UNUSED, key, TAG_W'($urandom), pos, wait_drain);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Command driver: take the next planned command, sit out its gap, then hold
  // valid until the transaction completes. Predict at acceptance.
  // --------------------------------------------------------------------------
  heap_cmd_t   cur_cmd;
  bit          cmd_loaded;
  int unsigned gap_left;

  always @(posedge clk) begin : command_driver
    bit offering;
    if (!rst_n) begin
      cmd_ch.valid    <= 1'b0;
      cmd_ch.command  <= CMD_INSERT;
      cmd_ch.new_key  <= '0;
      cmd_ch.new_tag  <= '0;
      cmd_ch.position <= '0;
      cmd_loaded = 1'b0;
      gap_left   = 0;
    end else begin
      offering = cmd_ch.valid;
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_results.push_back(apply_heap_command(cur_cmd));
        cmds_sent++;
        cmd_loaded = 1'b0;
        offering   = 1'b0;
      end
      if (!offering) begin
        if (!cmd_loaded && pending_cmds.size() > 0) begin
          cur_cmd    = pending_cmds.pop_front();
          cmd_loaded = 1'b1;
          gap_left   = cur_cmd.gap;
        end
        if (cmd_loaded) begin
          // Count down the idle gap; a marked command also waits for the
          // result queue to run dry.
          if (gap_left > 0) gap_left--;
          else if (!cur_cmd.wait_drain || expected_results.size() == 0) offering = 1'b1;
        end
      end
      // Single write of valid per edge, so a back-to-back command keeps it high.
      cmd_ch.valid <= offering;
      if (offering) begin
        cmd_ch.command  <= cur_cmd.command;
        cmd_ch.new_key  <= cur_cmd.key;
        cmd_ch.new_tag  <= cur_cmd.tag;
        cmd_ch.position <= cur_cmd.position;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each accepted result against the oldest prediction,
  // then drop ready for a random stall. Once, hold off for a long stretch so
  // the block backs up and stalls its command input.
  // --------------------------------------------------------------------------
  int unsigned stall_left;
  int unsigned hold_left;

  always @(posedge clk) begin : result_monitor
    heap_result_t want;
    bit           rdy;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: removed_key %0d status %0d count %0d",
                 $signed(res_ch.removed_key), res_ch.status, res_ch.count);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_ch.removed_key !== want.removed_key) begin
            $error("removed_key: expected %0d, actual %0d",
                   $signed(want.removed_key), $signed(res_ch.removed_key));
            mismatch_count++;
          end
          if (res_ch.removed_tag !== want.removed_tag) begin
            $error("removed_tag: expected 0x%h, actual 0x%h",
                   want.removed_tag, res_ch.removed_tag);
            mismatch_count++;
          end
          if (res_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_ch.status);
            mismatch_count++;
          end
          if (res_ch.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, res_ch.count);
            mismatch_count++;
          end
        end
        results_seen++;
        // Draw a stall for every result, except the one that opens the hold.
        if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
        else stall_left = $urandom_range(0, MAX_IDLE);
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      res_ch.ready <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Plan the run, release reset, wait for every result, report.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    int unsigned directed_n;
    bit          first;
    model_count   = 0;
    plan_count    = 0;

    // Directed: errors on an empty heap and the unused selector.
    plan_cmd(CMD_POP,       '0, '0, '0, 1'b0);
    plan_cmd(CMD_REMOVE_AT, '0, '0, 9'd1, 1'b0);
    plan_cmd(CMD_UNUSED,    32'hFFFF_FFFF, 16'hFFFF, 9'h1FF, 1'b0);
    // Extreme keys and tags, then a run of equal keys that must not swap.
    plan_cmd(CMD_INSERT, 32'h7FFF_FFFF, 16'hFFFF, '0, 1'b0);
    plan_cmd(CMD_INSERT, 32'h8000_0000, 16'h0000, '0, 1'b0);
    plan_cmd(CMD_INSERT, 32'd5,         16'h1111, '0, 1'b0);
    plan_cmd(CMD_INSERT, 32'd5,         16'h2222, '0, 1'b0);
    plan_cmd(CMD_INSERT, 32'd5,         16'h3333, '0, 1'b0);
    plan_cmd(CMD_INSERT, 32'hFFFF_FFFF, 16'hAAAA, '0, 1'b0);
    plan_cmd(CMD_INSERT, 32'd5,         16'h5555, 9'h1FF, 1'b0);
    // Bad positions: zero, one past the end, the top of the field.
    plan_cmd(CMD_REMOVE_AT, '0, '0, 9'd0, 1'b0);
    plan_cmd(CMD_REMOVE_AT, '0, '0, 9'd8, 1'b0);
    plan_cmd(CMD_REMOVE_AT, '0, '0, 9'h1FF, 1'b0);
    // Remove the last entry, then a hole that sifts up, then a pop whose
    // replacement faces two equal children.
    plan_cmd(CMD_REMOVE_AT, '0, '0, 9'd7, 1'b0);
    plan_cmd(CMD_REMOVE_AT, '0, '0, 9'd4, 1'b0);
    plan_cmd(CMD_POP,       '0, '0, '0, 1'b0);
    plan_cmd(CMD_INSERT, 32'd100, 16'hBEEF, '0, 1'b0);
    plan_cmd(CMD_REMOVE_AT, '0, '0, 9'd3, 1'b0);
    plan_cmd(CMD_INSERT, 32'h8000_0000, 16'hFFFF, '0, 1'b0);
    // Interior hole whose replacement sifts down.
    plan_cmd(CMD_REMOVE_AT, '0, '0, 9'd2, 1'b0);
    repeat (5) plan_cmd(CMD_POP, '0, '0, '0, 1'b0);
    directed_n = pending_cmds.size();

    // Random phases: churn, fill past full, churn near full, drain past
    // empty, churn on clustered keys. Each phase opens by pausing until
    // every outstanding result is back.
    phase = 0;
    while (pending_cmds.size() < directed_n + RANDOM_ITEMS) begin
      first = 1'b1;
      case (phase % 5)
        0: repeat (150) begin
          plan_random(55, 1'b0, first);
          first = 1'b0;
        end
        1: begin
          while (plan_count < CAPACITY) begin
            plan_random(85, 1'b0, first);
            first = 1'b0;
          end
          repeat (8) plan_cmd(CMD_INSERT, KEY_W'($urandom), TAG_W'($urandom),
                              CNT_W'($urandom), 1'b0);
        end
        2: repeat (120) begin
          plan_random(50, 1'b0, first);
          first = 1'b0;
        end
        3: begin
          while (plan_count > 0) begin
            plan_random(10, 1'b0, first);
            first = 1'b0;
          end
          repeat (6) plan_cmd(CMD_POP, KEY_W'($urandom), TAG_W'($urandom),
                              CNT_W'($urandom), 1'b0);
        end
        default: repeat (150) begin
          plan_random(55, 1'b1, first);
          first = 1'b0;
        end
      endcase
      phase++;
    end
    total_cmds = pending_cmds.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Hold until every command is sent and every result is back, then let
    // the block settle before reporting.
    while (cmds_sent != total_cmds || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
rtl/bmhq_pkg.sv
rtl/bmhq_if.sv
rtl/bmhq_ram.sv
rtl/bmhq_ctrl.sv
rtl/binary_max_heap_queue.sv
tb/sv/tb_binary_max_heap_queue.sv
